/* sv/assert_macros.svh */
// assertion macros used by the checker file mdiv_checker.sv
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* sv/mdiv_pkg.sv */
// types, constants and the restoring-division step for mul_div_96bit
// no dependencies
`default_nettype none

package mdiv_pkg;

    localparam int DATA_W     = 64;
    localparam int HALF_W     = 32;
    localparam int PROD_W     = DATA_W + HALF_W;
    localparam int DIV_STAGES = PROD_W;

    // one division stage: partial remainder, dividend bits still to come
    // at the top of work with quotient bits shifting in at the bottom
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [PROD_W-1:0] work;
        logic [DATA_W-1:0] divisor;
        logic              dz;
    } div_stage_t;

    typedef struct packed {
        logic [DATA_W-1:0] quotient;
        logic              overflow;
        logic              dz;
    } out_item_t;

    function automatic div_stage_t div_step(input div_stage_t s);
        logic [DATA_W:0] shifted;
        logic [DATA_W:0] diff;
        logic            take;
        div_stage_t      r;
        shifted   = {s.rem, s.work[PROD_W-1]};
        diff      = shifted - {1'b0, s.divisor};
        take      = (shifted >= {1'b0, s.divisor});
        r         = s;
        r.rem     = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        r.work    = {s.work[PROD_W-2:0], take};
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/mul_div_96bit.sv */
// mul_div_96bit: exact 96-bit product of a 64x32 multiply, divided by a 64-bit divisor
// depends on mdiv_pkg
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, multiplicand,        | in (stall out)
//          | multiplier, divisor                      |
//  output  | out_valid, out_stall, quotient,          | out (stall in)
//          | overflow, divide_by_zero                 |
//
// one item per cycle while in_stall is low
// pipeline: one multiply stage, one 96-bit add stage, 96 one-bit divide stages, output reg
// rst_n clears all valid bits; payload registers are not reset
// a stalled output parks the next result in a skid register; in_stall rises only
// while that skid register is full, and the whole pipeline holds in that cycle
`default_nettype none

module mul_div_96bit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [mdiv_pkg::DATA_W-1:0] multiplicand,
    input  wire logic [mdiv_pkg::HALF_W-1:0] multiplier,
    input  wire logic [mdiv_pkg::DATA_W-1:0] divisor,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [mdiv_pkg::DATA_W-1:0] quotient,
    output logic                             overflow,
    output logic                             divide_by_zero
);
    import mdiv_pkg::*;

    logic                enable;
    logic                in_accept;

    // multiply stage
    logic                s1_valid_reg;
    logic [DATA_W-1:0]   s1_lo_reg;
    logic [DATA_W-1:0]   s1_hi_reg;
    logic [DATA_W-1:0]   s1_div_reg;
    logic                s1_dz_reg;
    logic [DATA_W-1:0]   s1_lo_next;
    logic [DATA_W-1:0]   s1_hi_next;

    // divide stages; entry 0 is the add stage output
    logic                div_valid_reg [0:DIV_STAGES];
    div_stage_t          div_reg       [0:DIV_STAGES];
    div_stage_t          div_next      [0:DIV_STAGES];

    // output register and skid
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_reg;
    out_item_t           out_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    out_item_t           skid_reg;
    out_item_t           skid_next;
    out_item_t           res;
    logic                out_take;

    assign enable    = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign s1_lo_next = {{HALF_W{1'b0}}, multiplicand[HALF_W-1:0]}
                      * {{HALF_W{1'b0}}, multiplier};
    assign s1_hi_next = {{HALF_W{1'b0}}, multiplicand[DATA_W-1:HALF_W]}
                      * {{HALF_W{1'b0}}, multiplier};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            s1_lo_reg  <= s1_lo_next;
            s1_hi_reg  <= s1_hi_next;
            s1_div_reg <= divisor;
            s1_dz_reg  <= (divisor == '0);
        end
    end

    // add stage: assemble the exact 96-bit product
    assign div_next[0] = {{DATA_W{1'b0}},
                          {s1_hi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, s1_lo_reg},
                          s1_div_reg,
                          s1_dz_reg};

    genvar g;
    generate
        for (g = 1; g <= DIV_STAGES; g++)
        begin : g_div
            assign div_next[g] = div_step(div_reg[g-1]);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                div_valid_reg[i] <= 1'b0;
            end
        end
        else if (enable)
        begin
            div_valid_reg[0] <= s1_valid_reg;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                div_valid_reg[i] <= div_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // zero divisor forces quotient and overflow low
    always_comb
    begin
        res.dz       = div_reg[DIV_STAGES].dz;
        res.quotient = res.dz ? '0 : div_reg[DIV_STAGES].work[DATA_W-1:0];
        res.overflow = !res.dz && (div_reg[DIV_STAGES].work[PROD_W-1:DATA_W] != '0);
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!skid_valid_reg)
        begin
            if (div_valid_reg[DIV_STAGES])
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res;
                end
                else
                begin
                    skid_valid_next = 1'b1;
                    skid_next       = res;
                end
            end
            else if (out_take)
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (out_take)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign quotient       = out_reg.quotient;
    assign overflow       = out_reg.overflow;
    assign divide_by_zero = out_reg.dz;

endmodule

`default_nettype wire

/* sv/mdiv_checker.sv */
// port-level checks for mul_div_96bit, attached by the bind below
// depends on mdiv_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module mdiv_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_stall,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic [mdiv_pkg::DATA_W-1:0] quotient,
    input  wire logic                        overflow,
    input  wire logic                        divide_by_zero
);
    import mdiv_pkg::*;

    // a waiting result is never dropped
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // zero divisor gives a clean zero result
    `CHK_IMPLY(a_dz_result, clk, rst_n, out_valid && divide_by_zero, (quotient == '0) && !overflow)

    // input only backs up once a result is parked behind the output
    `CHK_IMPLY(a_empty_ready, clk, rst_n, !out_valid, !in_stall)

    // the skid is empty again the cycle after the output is taken
    `CHK_NEXT(a_skid_drain, clk, rst_n, in_stall && !out_stall, !in_stall)

endmodule

bind mul_div_96bit mdiv_checker u_mdiv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .quotient       (quotient),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
);

`default_nettype wire

/* tb/quotient_checker.sv */
// checker for mul_div_96bit: watches both channels, predicts the scaled quotient
// for every item taken and compares it with the result that comes out
// depends on mdiv_pkg for the field widths
module quotient_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [mdiv_pkg::DATA_W-1:0] multiplicand,
    input  logic [mdiv_pkg::HALF_W-1:0] multiplier,
    input  logic [mdiv_pkg::DATA_W-1:0] divisor,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [mdiv_pkg::DATA_W-1:0] quotient,
    input  logic                        overflow,
    input  logic                        divide_by_zero,
    output int                          mismatches,
    output int                          outstanding
);

    typedef struct {
        logic [mdiv_pkg::DATA_W-1:0] quotient;
        logic                        overflow;
        logic                        dz;
    } scaled_quot_t;

    scaled_quot_t pending_quots[$];
    int           err_cnt = 0;

    // exact 96-bit product, floor division, low 64 bits kept
    function automatic scaled_quot_t scale_divide(
        input logic [mdiv_pkg::DATA_W-1:0] a,
        input logic [mdiv_pkg::HALF_W-1:0] b,
        input logic [mdiv_pkg::DATA_W-1:0] d
    );
        logic [mdiv_pkg::PROD_W-1:0] prod;
        logic [mdiv_pkg::PROD_W-1:0] full_q;
        scaled_quot_t                r;
        r.quotient = '0;
        r.overflow = 1'b0;
        r.dz       = 1'b0;
        if (d == '0)
        begin
            r.dz = 1'b1;
        end
        else
        begin
            prod       = {{mdiv_pkg::HALF_W{1'b0}}, a} * {{mdiv_pkg::DATA_W{1'b0}}, b};
            full_q     = prod / {{mdiv_pkg::HALF_W{1'b0}}, d};
            r.quotient = full_q[mdiv_pkg::DATA_W-1:0];
            r.overflow = (full_q[mdiv_pkg::PROD_W-1:mdiv_pkg::DATA_W] != '0);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        scaled_quot_t exp_q;
        if (rst_n)
        begin
            // compare before pushing so a result can never match its own item
            if (out_valid && !out_stall)
            begin
                if (pending_quots.size() == 0)
                begin
                    $error("result with no item outstanding: quotient %h", quotient);
                    err_cnt++;
                end
                else
                begin
                    exp_q = pending_quots.pop_front();
                    if (quotient !== exp_q.quotient)
                    begin
                        $error("quotient: expected %h, got %h", exp_q.quotient, quotient);
                        err_cnt++;
                    end
                    if (overflow !== exp_q.overflow)
                    begin
                        $error("overflow: expected %b, got %b", exp_q.overflow, overflow);
                        err_cnt++;
                    end
                    if (divide_by_zero !== exp_q.dz)
                    begin
                        $error("divide_by_zero: expected %b, got %b", exp_q.dz,
                               divide_by_zero);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_quots.push_back(scale_divide(multiplicand, multiplier, divisor));
            mismatches  <= err_cnt;
            outstanding <= pending_quots.size();
        end
    end

endmodule

/* tb/tb_mul_div_96bit.sv */
// top of the mul_div_96bit testbench: clock, reset, item stimulus, output stalls
// and the verdict; depends on mdiv_pkg, mul_div_96bit and quotient_checker
module tb_mul_div_96bit;

    localparam int RAND_ITEMS  = 800;
    localparam int DRAIN_WAIT  = 150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic                        clk            = 1'b0;
    logic                        rst_n          = 1'b0;
    logic                        in_valid       = 1'b0;
    logic                        in_stall;
    logic [mdiv_pkg::DATA_W-1:0] multiplicand   = '0;
    logic [mdiv_pkg::HALF_W-1:0] multiplier     = '0;
    logic [mdiv_pkg::DATA_W-1:0] divisor        = '0;
    logic                        out_valid;
    logic                        out_stall      = 1'b0;
    logic [mdiv_pkg::DATA_W-1:0] quotient;
    logic                        overflow;
    logic                        divide_by_zero;

    int mismatches;
    int outstanding;
    int items_taken = 0;
    int tx_idle_pct = 24;
    int rx_idle_pct = 24;
    int cycle_cnt   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mul_div_96bit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .multiplicand   (multiplicand),
        .multiplier     (multiplier),
        .divisor        (divisor),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quotient       (quotient),
        .overflow       (overflow),
        .divide_by_zero (divide_by_zero)
    );

    quotient_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .multiplicand   (multiplicand),
        .multiplier     (multiplier),
        .divisor        (divisor),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quotient       (quotient),
        .overflow       (overflow),
        .divide_by_zero (divide_by_zero),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // offer one item, with random idle cycles first, and wait until it is taken
    task automatic send_item(
        input logic [mdiv_pkg::DATA_W-1:0] a,
        input logic [mdiv_pkg::HALF_W-1:0] b,
        input logic [mdiv_pkg::DATA_W-1:0] d
    );
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        multiplicand <= a;
        multiplier   <= b;
        divisor      <= d;
        do
            @(posedge clk);
        while (in_stall);
        items_taken++;
    endtask

    // full random half the time, else zero, all ones, one bit or a short value
    function automatic logic [63:0] shaped_word();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2: w = 64'd1 << $urandom_range(63);
            3, 4: w = w >> $urandom_range(63);
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        logic [63:0] a_w;
        logic [63:0] b_w;
        logic [63:0] d_w;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero divisor
        send_item('0, '0, '0);
        send_item('1, '1, '0);
        // zero operands and unit divisor
        send_item('0, '1, 64'd1);
        send_item('1, '0, 64'd1);
        send_item(64'd1, 32'd1, 64'd1);
        send_item('1, 32'd1, 64'd1);
        // quotient too wide, wraps (the second just reaches 2^64); then a full-width quotient that just fits
        send_item('1, '1, 64'd1);
        send_item(64'h8000_0000_0000_0000, 32'd2, 64'd1);
        send_item('1, 32'd2, 64'd2);
        // just fits versus just too wide
        send_item('1, '1, 64'h0000_0000_ffff_ffff);
        send_item('1, '1, 64'h0000_0000_ffff_fffe);
        // divisors of 2^32 and above, and one of 3
        send_item('1, '1, 64'h0000_0001_0000_0000);
        send_item('1, '1, 64'h8000_0000_0000_0000);
        send_item('1, '1, '1);
        send_item(64'h8000_0000_0000_0005, '1, 64'h8000_0000_0000_0001);
        send_item('1, '1, 64'hffff_ffff_ffff_fffe);
        send_item(64'd1, 32'd1, '1);
        send_item(64'h0123_4567_89ab_cdef, 32'hdead_beef, 64'd3);
        send_item(64'hfedc_ba98_7654_3210, 32'h8000_0000, 64'h0000_0123_4567_89ab);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // a stretch with no input idling, overlapping the stretch with no output idling
            tx_idle_pct = (i >= 350 && i < 500) ? 0 : 24;
            a_w = shaped_word();
            b_w = shaped_word();
            d_w = shaped_word();
            send_item(a_w, b_w[31:0], d_w);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // output stalls, with one long hold-off that backs the pipeline up
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_idle_pct = (items_taken >= 380 && items_taken < 520) ? 0 : 24;
            if (!hold_done && items_taken >= 150)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/mdiv_pkg.sv
sv/mul_div_96bit.sv
sv/mdiv_checker.sv
tb/quotient_checker.sv
tb/tb_mul_div_96bit.sv
